/* hw/rtl/dda_pkg.sv */
package dda_pkg;

  // Sequencer states of the line setup.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y
  } dda_state_e;

  // Status of the shared divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Request kinds carried in tuser.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

endpackage

/* hw/rtl/dda_div.sv */
// Restoring divider, one quotient bit per cycle.
// It computes floor((num << FRAC_BITS) / den) for num <= den, so the
// quotient has FRAC_BITS + 1 bits.
module dda_div #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [COORD_BITS-1:0]    num_i,
  input  logic [COORD_BITS-1:0]    den_i,
  output dda_pkg::div_status_t     status_o,
  output logic [FRAC_BITS:0]       quot_o
);

  localparam int unsigned CntW = $clog2(FRAC_BITS + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic                  first_q, first_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [COORD_BITS-1:0] rem_q, rem_d;
  logic [COORD_BITS-1:0] den_q, den_d;
  logic [FRAC_BITS:0]    quot_q, quot_d;

  logic [COORD_BITS:0]   shifted;
  logic [COORD_BITS:0]   diff;
  logic                  ge;

  // The first iteration compares the numerator itself; the rest shift first.
  assign shifted = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign ge      = (shifted >= {1'b0, den_q});
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    first_d = first_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quot_d  = quot_q;
    if (start_i) begin
      busy_d  = 1'b1;
      first_d = 1'b1;
      cnt_d   = CntW'(FRAC_BITS);
      rem_d   = num_i;
      den_d   = den_i;
      quot_d  = '0;
    end else if (busy_q) begin
      first_d = 1'b0;
      rem_d   = ge ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
      quot_d  = {quot_q[FRAC_BITS-1:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      first_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      first_q <= first_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quot_q;

endmodule

/* hw/rtl/dda_line_rasterizer.sv */
// A step request shows its pixel on the master side in the cycle after it is accepted.
// Throughput: step requests are taken one per cycle while the output register drains.
// A start request with a nonzero step holds the slave side while the
// shared one-bit-per-cycle divider runs FRAC_BITS + 1 iterations for x, then again for y.
// Reset (rst_ni low, asynchronous) clears the line state, so no line is active afterward.
module dda_line_rasterizer #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // Slave side.
  input  logic                                     s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // tdata fields from bit 0 up: x_start, y_start, x_end, y_end, zero fill.
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]        s_axis_tdata_i,
  // tuser: cmd (0 starts a line, 1 asks for the next pixel).
  input  logic                                     s_axis_tuser_i,
  // Master side.
  output logic                                     m_axis_tvalid_o,
  input  logic                                     m_axis_tready_i,
  // tdata fields from bit 0 up: x_pixel, y_pixel, zero fill.
  output logic [((2*COORD_BITS+7)/8)*8-1:0]        m_axis_tdata_o,
  // tlast: last_pixel, set on the final pixel of the line.
  output logic                                     m_axis_tlast_o
);

  localparam int unsigned AccW = COORD_BITS + FRAC_BITS;
  localparam int unsigned IncW = FRAC_BITS + 2;
  localparam int unsigned OutW = ((2*COORD_BITS+7)/8)*8;

  // Request decode. Endpoints are unsigned; deltas are kept as sign and magnitude.
  logic [COORD_BITS-1:0] xs, ys, xe, ye;
  logic                  x_neg, y_neg;
  logic [COORD_BITS-1:0] adx, ady, step;

  assign xs    = s_axis_tdata_i[COORD_BITS-1:0];
  assign ys    = s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS];
  assign xe    = s_axis_tdata_i[3*COORD_BITS-1:2*COORD_BITS];
  assign ye    = s_axis_tdata_i[4*COORD_BITS-1:3*COORD_BITS];
  assign x_neg = (xe < xs);
  assign y_neg = (ye < ys);
  assign adx   = x_neg ? (xs - xe) : (xe - xs);
  assign ady   = y_neg ? (ys - ye) : (ye - ys);
  assign step  = (adx > ady) ? adx : ady;

  dda_pkg::dda_state_e   state_q, state_d;
  logic [COORD_BITS:0]   pixels_left_q, pixels_left_d;
  logic [AccW-1:0]       x_acc_q, x_acc_d, y_acc_q, y_acc_d;
  logic [IncW-1:0]       x_inc_q, x_inc_d, y_inc_q, y_inc_d;
  logic                  x_neg_q, y_neg_q;
  logic [COORD_BITS-1:0] ady_q;
  logic                  m_valid_q, m_valid_d;
  logic [COORD_BITS-1:0] x_pix_q, y_pix_q;
  logic                  last_q;

  logic                  s_acc, start_fire, step_fire;
  logic                  div_start;
  logic [COORD_BITS-1:0] div_num, div_den;
  dda_pkg::div_status_t  div_status;
  logic [FRAC_BITS:0]    div_quot;
  logic [IncW-1:0]       quot_ext, quot_neg;

  // The setup sequencer only takes requests in idle, and only when the
  // output register is empty or being drained this cycle.
  assign s_axis_tready_o = (state_q == dda_pkg::ST_IDLE) && (!m_valid_q || m_axis_tready_i);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign start_fire      = s_acc && (s_axis_tuser_i == dda_pkg::CMD_START);
  assign step_fire       = s_acc && (s_axis_tuser_i == dda_pkg::CMD_STEP) &&
                           (pixels_left_q != '0);

  // One shared divider produces |d| / step for x, then for y.
  dda_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .status_o (div_status),
    .quot_o   (div_quot)
  );

  assign quot_ext = {1'b0, div_quot};
  assign quot_neg = -quot_ext;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dda_pkg::ST_IDLE: begin
        if (start_fire && (step != '0)) begin
          state_d = dda_pkg::ST_DIV_X;
        end
      end
      dda_pkg::ST_DIV_X: begin
        if (div_status.done) begin
          state_d = dda_pkg::ST_DIV_Y;
        end
      end
      dda_pkg::ST_DIV_Y: begin
        if (div_status.done) begin
          state_d = dda_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dda_pkg::ST_IDLE;
      end
    endcase
  end

  // Divider requests. The y division reuses the step count, which still sits
  // untouched in pixels_left_q because no pixel can be taken during setup.
  always_comb begin
    div_start = 1'b0;
    div_num   = ady_q;
    div_den   = pixels_left_q[COORD_BITS-1:0];
    case (state_q)
      dda_pkg::ST_IDLE: begin
        div_start = start_fire && (step != '0);
        div_num   = adx;
        div_den   = step;
      end
      dda_pkg::ST_DIV_X: begin
        div_start = div_status.done;
      end
      dda_pkg::ST_DIV_Y: begin
        div_start = 1'b0;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Line state. A start request loads the start point and the step count and
  // clears the increments; the divider fills them in afterward. Each pixel
  // adds the sign-extended increments to the accumulators.
  always_comb begin
    pixels_left_d = pixels_left_q;
    x_acc_d       = x_acc_q;
    y_acc_d       = y_acc_q;
    x_inc_d       = x_inc_q;
    y_inc_d       = y_inc_q;
    if (start_fire) begin
      pixels_left_d = {1'b0, step};
      x_acc_d       = {xs, {FRAC_BITS{1'b0}}};
      y_acc_d       = {ys, {FRAC_BITS{1'b0}}};
      x_inc_d       = '0;
      y_inc_d       = '0;
    end else if (step_fire) begin
      pixels_left_d = pixels_left_q - 1'b1;
      x_acc_d       = x_acc_q + {{(COORD_BITS-2){x_inc_q[IncW-1]}}, x_inc_q};
      y_acc_d       = y_acc_q + {{(COORD_BITS-2){y_inc_q[IncW-1]}}, y_inc_q};
    end
    if (div_status.done && (state_q == dda_pkg::ST_DIV_X)) begin
      x_inc_d = x_neg_q ? quot_neg : quot_ext;
    end
    if (div_status.done && (state_q == dda_pkg::ST_DIV_Y)) begin
      y_inc_d = y_neg_q ? quot_neg : quot_ext;
    end
  end

  // The output register holds a pixel until the master side takes it.
  assign m_valid_d = (m_valid_q && !m_axis_tready_i) || step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= dda_pkg::ST_IDLE;
      pixels_left_q <= '0;
      x_acc_q       <= '0;
      y_acc_q       <= '0;
      x_inc_q       <= '0;
      y_inc_q       <= '0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      pixels_left_q <= pixels_left_d;
      x_acc_q       <= x_acc_d;
      y_acc_q       <= y_acc_d;
      x_inc_q       <= x_inc_d;
      y_inc_q       <= y_inc_d;
      m_valid_q     <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_fire) begin
      x_neg_q <= x_neg;
      y_neg_q <= y_neg;
      ady_q   <= ady;
    end
    if (step_fire) begin
      x_pix_q <= x_acc_q[AccW-1:FRAC_BITS];
      y_pix_q <= y_acc_q[AccW-1:FRAC_BITS];
      last_q  <= (pixels_left_q == (COORD_BITS+1)'(1));
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OutW'({y_pix_q, x_pix_q});
  assign m_axis_tlast_o  = last_q;

  // The divider only runs while the sequencer is in one of its setup states.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_status.busy || div_status.done) |-> (state_q != dda_pkg::ST_IDLE))
    else $error("divider active while the sequencer is idle");

  // A pixel request on an active line always lands in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire |=> m_axis_tvalid_o)
    else $error("pixel request accepted but no pixel presented");

  // Outside a start request the pixel count only holds or counts down by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_fire |=> ((pixels_left_q == $past(pixels_left_q)) ||
                     (pixels_left_q == $past(pixels_left_q) - 1'b1)))
    else $error("pixel count changed without a start request");

  // The step count must not move while the divider still needs it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dda_pkg::ST_DIV_Y) |-> $stable(pixels_left_q))
    else $error("step count changed during setup");

endmodule
